### rtl/gpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) parity encoder package
// Field sizes, item types, coefficient tables and the Cantor-basis multiply.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int BYTE_W   = 8;
  localparam int NUM_DATA = 8;
  localparam int NUM_PAR  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [BYTE_W-1:0][BYTE_W-1:0] basis_t;

  // Reduction polynomial 0x11d without its top bit
  localparam byte_t POLY_LOW = 8'h1d;

  // Cantor basis to polynomial basis, entry k for bit k
  localparam basis_t BASIS_VEC = {
    8'd230, 8'd88, 8'd200, 8'd86, 8'd146, 8'd152, 8'd214, 8'd1
  };

  // Polynomial basis to Cantor basis, entry j for bit j
  localparam basis_t INV_BASIS_VEC = {
    8'h12, 8'h56, 8'hf0, 8'h72, 8'h64, 8'h5c, 8'h68, 8'h01
  };

  localparam byte_t ENC_MATRIX [NUM_PAR][NUM_DATA] = '{
    '{8'd1,  8'd2,  8'd3,   8'd5,   8'd8,   8'd13,  8'd21,  8'd34},
    '{8'd55, 8'd89, 8'd144, 8'd233, 8'd1,   8'd7,   8'd0,   8'd197},
    '{8'd11, 8'd29, 8'd47,  8'd83,  8'd131, 8'd173, 8'd211, 8'd251},
    '{8'd0,  8'd1,  8'd254, 8'd127, 8'd63,  8'd31,  8'd15,  8'd9}
  };

  localparam byte_t BFLY_FACTOR [7] = '{
    8'd2, 8'd53, 8'd91, 8'd197, 8'd7, 8'd144, 8'd233
  };

  // Factors used by the two butterfly layers
  localparam byte_t BFLY_L0_A = BFLY_FACTOR[0];
  localparam byte_t BFLY_L0_B = BFLY_FACTOR[1];
  localparam byte_t BFLY_L1   = BFLY_FACTOR[4];

  typedef logic [NUM_DATA-1:0][BYTE_W-1:0] data_vec_t;
  typedef logic [NUM_PAR-1:0][BYTE_W-1:0]  par_vec_t;

  typedef struct packed {
    data_vec_t data;
    par_vec_t  par;
    logic      last;
  } cell_item_t;

  typedef struct packed {
    par_vec_t par;
    logic     last;
  } bfly_item_t;

  function automatic byte_t lin_map(byte_t v, basis_t vec);
    byte_t r;
    r = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[k]) r = r ^ vec[k];
    end
    return r;
  endfunction

  function automatic byte_t gf_mul(byte_t c, byte_t v);
    byte_t a;
    byte_t b;
    byte_t x;
    byte_t r;
    a = lin_map(c, BASIS_VEC);
    b = lin_map(v, BASIS_VEC);
    x = a;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? POLY_LOW : byte_t'(0));
    end
    return lin_map(r, INV_BASIS_VEC);
  endfunction

endpackage

### rtl/gpe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) parity encoder channels
// Valid/ready interfaces for shard bytes in and parity bytes out.
// ----------------------------------------------------------------------------
interface gpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_0;
  logic [7:0] data_1;
  logic [7:0] data_2;
  logic [7:0] data_3;
  logic [7:0] data_4;
  logic [7:0] data_5;
  logic [7:0] data_6;
  logic [7:0] data_7;
  logic       end_in;

  modport source (
    output valid, data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7, end_in,
    input  ready
  );
  modport sink (
    input  valid, data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7, end_in,
    output ready
  );
endinterface

interface gpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_0;
  logic [7:0] parity_1;
  logic [7:0] parity_2;
  logic [7:0] parity_3;
  logic       end_out;

  modport source (
    output valid, parity_0, parity_1, parity_2, parity_3, end_out,
    input  ready
  );
  modport sink (
    input  valid, parity_0, parity_1, parity_2, parity_3, end_out,
    output ready
  );
endinterface

### rtl/gpe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix column cell
// Multiplies the leading data byte by one coefficient column, folds the
// products into the running parity and hands the rest on to the next cell.
// ----------------------------------------------------------------------------
module gpe_cell import gpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  par_vec_t   coef,
  input  cell_item_t up,
  input  logic       up_valid,
  output logic       up_ready,
  output cell_item_t down,
  output logic       down_valid,
  input  logic       down_ready
);

  cell_item_t item_next;

  assign up_ready = !down_valid || down_ready;

  always_comb begin
    item_next.data = up.data >> BYTE_W;
    item_next.last = up.last;
    for (int r = 0; r < NUM_PAR; r++) begin
      item_next.par[r] = up.par[r] ^ gf_mul(coef[r], up.data[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down <= item_next;
    end
  end

endmodule

### rtl/gpe_bfly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Butterfly layer cell
// Two butterflies on (par[0], par[1]) and (par[2], par[3]): y ^= x,
// then x ^= c * y.
// ----------------------------------------------------------------------------
module gpe_bfly import gpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  byte_t      factor_a,
  input  byte_t      factor_b,
  input  bfly_item_t up,
  input  logic       up_valid,
  output logic       up_ready,
  output bfly_item_t down,
  output logic       down_valid,
  input  logic       down_ready
);

  bfly_item_t item_next;
  byte_t      y_a;
  byte_t      y_b;

  assign up_ready = !down_valid || down_ready;

  always_comb begin
    y_a = up.par[1] ^ up.par[0];
    y_b = up.par[3] ^ up.par[2];
    item_next.par[0] = up.par[0] ^ gf_mul(factor_a, y_a);
    item_next.par[1] = y_a;
    item_next.par[2] = up.par[2] ^ gf_mul(factor_b, y_b);
    item_next.par[3] = y_b;
    item_next.last   = up.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down <= item_next;
    end
  end

endmodule

### rtl/gf256_parity_encoder_8x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) parity encoder, 8 data shards to 4 parity shards
// A row of eight column cells builds the parity bytes, two butterfly
// layers mix them.
//
//   channel  direction  payload
//   shards   in         data_0 .. data_7, end_in
//   parity   out        parity_0 .. parity_3, end_out
//
// One transfer per cycle in and out while the output takes them; each cell
// holds one register (eight column cells, two butterfly layers).
// Each cell registers its item and is ready whenever it is empty or its
// neighbour takes its item, so a stall at the output fills bubbles first.
// Synchronous reset empties every cell.
// ----------------------------------------------------------------------------
module gf256_parity_encoder_8x4 import gpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gpe_in_if.sink    shards,
  gpe_out_if.source parity
);

  cell_item_t chain       [NUM_DATA+1];
  logic       chain_valid [NUM_DATA+1];
  logic       chain_ready [NUM_DATA+1];
  par_vec_t   coef        [NUM_DATA];

  bfly_item_t l0_in;
  bfly_item_t l0_out;
  bfly_item_t l1_in;
  bfly_item_t l1_out;
  logic       l0_valid;
  logic       l0_ready;
  logic       l1_valid;

  assign chain[0].data = {shards.data_7, shards.data_6, shards.data_5, shards.data_4,
                          shards.data_3, shards.data_2, shards.data_1, shards.data_0};
  assign chain[0].par  = '0;
  assign chain[0].last = shards.end_in;
  assign chain_valid[0] = shards.valid;
  assign shards.ready   = chain_ready[0];

  for (genvar k = 0; k < NUM_DATA; k++) begin : g_cell
    for (genvar r = 0; r < NUM_PAR; r++) begin : g_coef
      assign coef[k][r] = ENC_MATRIX[r][k];
    end

    gpe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .coef       (coef[k]),
      .up         (chain[k]),
      .up_valid   (chain_valid[k]),
      .up_ready   (chain_ready[k]),
      .down       (chain[k+1]),
      .down_valid (chain_valid[k+1]),
      .down_ready (chain_ready[k+1])
    );
  end

  assign l0_in.par  = chain[NUM_DATA].par;
  assign l0_in.last = chain[NUM_DATA].last;

  gpe_bfly u_bfly_l0 (
    .clk        (clk),
    .rst        (rst),
    .factor_a   (BFLY_L0_A),
    .factor_b   (BFLY_L0_B),
    .up         (l0_in),
    .up_valid   (chain_valid[NUM_DATA]),
    .up_ready   (chain_ready[NUM_DATA]),
    .down       (l0_out),
    .down_valid (l0_valid),
    .down_ready (l0_ready)
  );

  // pair 0 with 2 and 1 with 3
  assign l1_in.par  = {l0_out.par[3], l0_out.par[1], l0_out.par[2], l0_out.par[0]};
  assign l1_in.last = l0_out.last;

  gpe_bfly u_bfly_l1 (
    .clk        (clk),
    .rst        (rst),
    .factor_a   (BFLY_L1),
    .factor_b   (BFLY_L1),
    .up         (l1_in),
    .up_valid   (l0_valid),
    .up_ready   (l0_ready),
    .down       (l1_out),
    .down_valid (l1_valid),
    .down_ready (parity.ready)
  );

  assign parity.valid    = l1_valid;
  assign parity.parity_0 = l1_out.par[0];
  assign parity.parity_1 = l1_out.par[2];
  assign parity.parity_2 = l1_out.par[1];
  assign parity.parity_3 = l1_out.par[3];
  assign parity.end_out  = l1_out.last;

endmodule

### tb/gpe_parity_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity encoder checker
// Watches both channels of the GF(2^8) 8x4 parity encoder. Each shard
// transfer is encoded by a local Cantor-basis predictor into the four
// mixed parity bytes and the end flag. Each parity transfer is compared
// field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module gpe_parity_check import gpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  gpe_in_if    shards,
  gpe_out_if   parity,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [3:0][7:0] par;
    logic            last;
  } parity_word_t;

  localparam logic [7:0] FIELD_POLY_LOW = 8'h1d;

  localparam logic [7:0] CANTOR_BASIS [8] = '{
    8'd1, 8'd214, 8'd152, 8'd146, 8'd86, 8'd200, 8'd88, 8'd230
  };

  localparam logic [7:0] MIX_FACTOR [7] = '{
    8'd2, 8'd53, 8'd91, 8'd197, 8'd7, 8'd144, 8'd233
  };

  localparam logic [7:0] SHARD_COEFF [4][8] = '{
    '{8'd1,  8'd2,  8'd3,   8'd5,   8'd8,   8'd13,  8'd21,  8'd34},
    '{8'd55, 8'd89, 8'd144, 8'd233, 8'd1,   8'd7,   8'd0,   8'd197},
    '{8'd11, 8'd29, 8'd47,  8'd83,  8'd131, 8'd173, 8'd211, 8'd251},
    '{8'd0,  8'd1,  8'd254, 8'd127, 8'd63,  8'd31,  8'd15,  8'd9}
  };

  logic [7:0]   poly_to_cantor [256];
  parity_word_t expected_parity_q [$];

  function automatic logic [7:0] to_poly(logic [7:0] v);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) acc ^= CANTOR_BASIS[k];
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_times(logic [7:0] c, logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] acc;
    a   = to_poly(c);
    b   = to_poly(v);
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LOW : 8'h00);
    end
    return poly_to_cantor[acc];
  endfunction

  function automatic void mix(inout logic [7:0] x, inout logic [7:0] y, input logic [7:0] c);
    y = y ^ x;
    x = x ^ gf_times(c, y);
  endfunction

  function automatic parity_word_t encode_parity(data_vec_t d, logic last);
    logic [7:0]   p [4];
    parity_word_t w;
    for (int r = 0; r < 4; r++) begin
      p[r] = '0;
      for (int c = 0; c < 8; c++) begin
        p[r] ^= gf_times(SHARD_COEFF[r][c], d[c]);
      end
    end
    mix(p[0], p[1], MIX_FACTOR[0]);
    mix(p[2], p[3], MIX_FACTOR[1]);
    mix(p[0], p[2], MIX_FACTOR[4]);
    mix(p[1], p[3], MIX_FACTOR[4]);
    for (int r = 0; r < 4; r++) begin
      w.par[r] = p[r];
    end
    w.last = last;
    return w;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %02h got %02h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    for (int i = 0; i < 256; i++) begin
      poly_to_cantor[to_poly(i[7:0])] = i[7:0];
    end
  end

  always @(posedge clk) begin
    parity_word_t exp_w;
    if (!rst) begin
      if (parity.valid && parity.ready) begin
        if (expected_parity_q.size() == 0) begin
          $display("%0t: parity transfer with nothing expected, got %02h %02h %02h %02h %b",
                   $time, parity.parity_0, parity.parity_1, parity.parity_2,
                   parity.parity_3, parity.end_out);
          errors++;
        end else begin
          exp_w = expected_parity_q.pop_front();
          check_field("parity_0", exp_w.par[0], parity.parity_0);
          check_field("parity_1", exp_w.par[1], parity.parity_1);
          check_field("parity_2", exp_w.par[2], parity.parity_2);
          check_field("parity_3", exp_w.par[3], parity.parity_3);
          check_field("end_out", {7'd0, exp_w.last}, {7'd0, parity.end_out});
        end
      end
      if (shards.valid && shards.ready) begin
        expected_parity_q.insert(expected_parity_q.size(), encode_parity(
          {shards.data_7, shards.data_6, shards.data_5, shards.data_4,
           shards.data_3, shards.data_2, shards.data_1, shards.data_0},
          shards.end_in));
      end
    end
    pending <= expected_parity_q.size();
  end

endmodule

### tb/gf256_parity_encoder_8x4_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity encoder testbench
// Drives shard bytes into the GF(2^8) 8x4 parity encoder: a directed set of
// edge values and single-shard bytes, then shard runs with random content
// closed by the end flag. Both sides stall at random, with a stretch of
// full throughput and one long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module gf256_parity_encoder_8x4_test;
  import gpe_pkg::*;

  localparam int NUM_RANDOM     = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   stall_on = 1'b1;
  bit   hold_req = 1'b0;
  int   errors;
  int   pending;
  int   quiet_cycles = 0;

  gpe_in_if  shards ();
  gpe_out_if parity ();

  gf256_parity_encoder_8x4 i_dut (
    .clk    (clk),
    .rst    (rst),
    .shards (shards),
    .parity (parity)
  );

  gpe_parity_check i_check (
    .clk     (clk),
    .rst     (rst),
    .shards  (shards),
    .parity  (parity),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic offer_shards(input data_vec_t d, input logic last);
    while (stall_on && $urandom_range(99) < 22) begin
      shards.valid <= 1'b0;
      @(posedge clk);
    end
    shards.valid  <= 1'b1;
    shards.data_0 <= d[0];
    shards.data_1 <= d[1];
    shards.data_2 <= d[2];
    shards.data_3 <= d[3];
    shards.data_4 <= d[4];
    shards.data_5 <= d[5];
    shards.data_6 <= d[6];
    shards.data_7 <= d[7];
    shards.end_in <= last;
    @(posedge clk);
    while (!shards.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (shards.valid && shards.ready) || (parity.valid && parity.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sink_drive
    parity.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        parity.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      parity.ready <= !stall_on || ($urandom_range(99) >= 22);
    end
  end

  initial begin : stimulus
    data_vec_t d;
    int        run_left;
    shards.valid  = 1'b0;
    shards.data_0 = '0;
    shards.data_1 = '0;
    shards.data_2 = '0;
    shards.data_3 = '0;
    shards.data_4 = '0;
    shards.data_5 = '0;
    shards.data_6 = '0;
    shards.data_7 = '0;
    shards.end_in = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    offer_shards('0, 1'b0);
    offer_shards('1, 1'b1);
    for (int k = 0; k < NUM_DATA; k++) begin
      d    = '0;
      d[k] = 8'h01;
      offer_shards(d, k[0]);
    end
    for (int k = 0; k < NUM_DATA; k++) begin
      d    = '0;
      d[k] = 8'hff;
      offer_shards(d, !k[0]);
    end
    offer_shards({NUM_DATA{8'haa}}, 1'b0);
    offer_shards({NUM_DATA{8'h55}}, 1'b1);
    for (int k = 0; k < NUM_DATA; k++) begin
      d[k] = 8'h01 << k;
    end
    offer_shards(d, 1'b0);

    run_left = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      stall_on = !(n >= 700 && n < 1000);
      if (n == 1200) hold_req = 1'b1;
      if (run_left == 0) run_left = $urandom_range(48, 1);
      for (int k = 0; k < NUM_DATA; k++) begin
        case ($urandom_range(7))
          0:       d[k] = 8'h00;
          1:       d[k] = 8'hff;
          default: d[k] = 8'($urandom);
        endcase
      end
      run_left--;
      offer_shards(d, run_left == 0);
    end
    shards.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $display("%0t: %0d parity words never arrived", $time, pending);
    end
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gpe_pkg.sv
rtl/gpe_if.sv
rtl/gpe_cell.sv
rtl/gpe_bfly.sv
rtl/gf256_parity_encoder_8x4.sv
tb/gpe_parity_check.sv
tb/gf256_parity_encoder_8x4_test.sv
